### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define CHTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define CHTI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/chti_pkg.sv
package chti_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    localparam int unsigned MUL_AW = 32;
    localparam int unsigned MUL_BW = 64;
    localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

    localparam int unsigned DIV_NW = 65;
    localparam int unsigned DIV_DW = 32;
    localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [63:0] SAT_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
    } t_item;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCW-1:0] cnt;
    } t_qstat;

endpackage

### rtl/chti_if.sv
interface chti_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;

    modport source (output valid, op, point_x, point_y, query_x, input ready);
    modport sink   (input valid, op, point_x, point_y, query_x, output ready);
endinterface

interface chti_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

### rtl/chti_front.sv
module chti_front import chti_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chti_in_if.sink   i_in,
    output logic      o_valid,
    output t_item     o_item,
    input  logic      i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    // decode op, drop fields the command does not use
    always_comb begin
        n_item    = '0;
        n_item.op = t_op'(i_in.op);
        case (t_op'(i_in.op))
            OP_APPEND: begin
                n_item.px = i_in.point_x;
                n_item.py = i_in.point_y;
            end
            OP_QUERY: begin
                n_item.qx = i_in.query_x;
            end
            default: begin
                n_item.px = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/chti_fifo.sv
module chti_fifo import chti_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_item  i_item,
    output logic   o_ready,
    output logic   o_valid,
    output t_item  o_item,
    input  logic   i_ready,
    output t_qstat o_stat
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = r_cnt != QCW'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    assign o_stat.full  = !o_ready;
    assign o_stat.empty = !o_valid;
    assign o_stat.cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### rtl/chti_mul.sv
module chti_mul import chti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_AW-1:0] i_a,
    input  logic [MUL_BW-1:0] i_b,
    output logic              o_done,
    output logic [MUL_PW-1:0] o_prod
);

    logic [3:0]          r_ph;
    logic [MUL_AW-1:0]   r_a;
    logic [MUL_BW-1:0]   r_b;
    logic [63:0]         r_lo;
    logic [63:0]         r_hi;
    logic [MUL_PW-1:0]   r_prod;
    logic [31:0]         w_half;
    logic [63:0]         w_pp;

    // one 32x32 multiplier, low then high half of b
    assign w_half = r_ph[0] ? r_b[31:0] : r_b[63:32];
    assign w_pp   = 64'(r_a) * 64'(w_half);
    assign o_done = r_ph[3];
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
        end else begin
            r_ph <= {r_ph[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_ph[0]) begin
            r_lo <= w_pp;
        end
        if (r_ph[1]) begin
            r_hi <= w_pp;
        end
        if (r_ph[2]) begin
            r_prod <= MUL_PW'(r_lo) + {r_hi, 32'b0};
        end
    end

endmodule

### rtl/chti_div.sv
module chti_div import chti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [DIV_CW-1:0]   r_cnt;
    logic [DIV_DW-1:0]   r_rem;
    logic [DIV_DW-1:0]   r_den;
    logic [DIV_NW-1:0]   r_quo;
    logic [DIV_DW:0]     w_sh;
    logic [DIV_DW:0]     w_diff;
    logic                w_ge;

    // restoring, one quotient bit per cycle
    assign w_sh   = {r_rem, r_quo[DIV_NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
        end
    end

endmodule

### rtl/chti_back.sv
module chti_back import chti_pkg::*; #(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_ready,
    output logic               o_valid,
    output logic signed [31:0] o_value,
    output t_status            o_status,
    input  logic               i_ready
);

    localparam int unsigned IW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned HW = FRAC_BITS + 4;
    localparam logic signed [HW-1:0] ONE     = HW'(1) << F;
    localparam logic signed [63:0]   I32_MAX = 64'sh7FFF_FFFF;
    localparam logic signed [63:0]   I32_MIN = -64'sh8000_0000;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CHK = 9'b000000100,
        S_NEXT_RD  = 9'b000001000,
        S_NEXT_CHK = 9'b000010000,
        S_ISSUE    = 9'b000100000,
        S_WAIT     = 9'b001000000,
        S_FIN      = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    typedef enum logic [3:0] {
        STP_T, STP_T2, STP_T3, STP_ML, STP_DL, STP_MR, STP_DR,
        STP_H00, STP_H01, STP_H10, STP_H11
    } t_step;

    // knot store
    logic signed [31:0] r_xmem [MAX_POINTS];
    logic signed [31:0] r_ymem [MAX_POINTS];
    logic signed [31:0] r_rd_x;
    logic signed [31:0] r_rd_y;
    logic [IW-1:0]      w_raddr;
    logic               w_we;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic signed [31:0] r_last_x, n_last_x;
    logic [CW-1:0]      r_k, n_k;
    logic signed [31:0] r_q, n_q;
    logic signed [31:0] r_xm, n_xm, r_ym, n_ym;
    logic signed [31:0] r_x0, n_x0, r_y0, n_y0;
    logic signed [31:0] r_x1, n_x1, r_y1, n_y1;
    logic signed [31:0] r_x2, n_x2, r_y2, n_y2;
    logic               r_left, n_left, r_right, n_right;
    t_step              r_step, n_step;
    logic [F-1:0]       r_t, n_t, r_t2, n_t2, r_t3, n_t3;
    logic signed [63:0] r_secl, n_secl, r_secr, n_secr;
    logic signed [63:0] r_acc, n_acc;
    logic signed [31:0] r_res_val, n_res_val;
    t_status            r_res_st, n_res_st;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_val, n_out_val;
    t_status            r_out_st, n_out_st;

    logic [CW-1:0]      w_k1;
    logic [32:0]        w_dx33, w_dxl33, w_dxr33, w_qd33;
    logic signed [32:0] w_dy, w_dyl, w_dyr;
    logic [32:0]        w_dylm, w_dyrm, w_y0m, w_y1m;
    logic signed [HW-1:0] w_te, w_t2e, w_t3e;
    logic signed [HW-1:0] w_h00, w_h01, w_h10, w_h11, w_h;
    logic [HW-1:0]      w_hm;
    logic signed [63:0] w_s0, w_s1, w_s0r, w_s1r, w_d0, w_d1;
    logic [63:0]        w_d0m, w_d1m;
    logic               w_vneg;
    logic [MUL_BW-1:0]  w_vm;
    logic signed [63:0] w_lim_p, w_lim_n;

    logic               w_mul_start, w_mul_done;
    logic [MUL_AW-1:0]  w_mul_a;
    logic [MUL_BW-1:0]  w_mul_b;
    logic [MUL_PW-1:0]  w_prod;
    logic               w_div_start, w_div_done;
    logic [DIV_NW-1:0]  w_num;
    logic [DIV_DW-1:0]  w_den;
    logic [DIV_NW-1:0]  w_quo;

    logic               w_is_div, w_skip, w_unit_done;
    logic [63:0]        w_qm, w_pm;
    logic signed [63:0] w_sec, w_term, w_sum, w_res;

    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_val;
    assign o_status = r_out_st;

    assign w_lim_p = signed'(SAT_LIM);
    assign w_lim_n = -w_lim_p;

    assign w_k1    = r_k + CW'(1);
    assign w_dx33  = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign w_dxl33 = {r_x0[31], r_x0} - {r_xm[31], r_xm};
    assign w_dxr33 = {r_x2[31], r_x2} - {r_x1[31], r_x1};
    assign w_qd33  = {r_q[31], r_q} - {r_x0[31], r_x0};
    assign w_dy    = 33'(r_y1) - 33'(r_y0);
    assign w_dyl   = 33'(r_y0) - 33'(r_ym);
    assign w_dyr   = 33'(r_y2) - 33'(r_y1);
    assign w_dylm  = w_dyl[32] ? 33'(-w_dyl) : 33'(w_dyl);
    assign w_dyrm  = w_dyr[32] ? 33'(-w_dyr) : 33'(w_dyr);
    assign w_y0m   = r_y0[31] ? 33'(-33'(r_y0)) : 33'(r_y0);
    assign w_y1m   = r_y1[31] ? 33'(-33'(r_y1)) : 33'(r_y1);

    // Hermite basis
    assign w_te  = signed'(HW'(r_t));
    assign w_t2e = signed'(HW'(r_t2));
    assign w_t3e = signed'(HW'(r_t3));
    assign w_h00 = (w_t3e <<< 1) - (w_t2e + (w_t2e <<< 1)) + ONE;
    assign w_h01 = (w_t2e + (w_t2e <<< 1)) - (w_t3e <<< 1);
    assign w_h10 = w_t3e - (w_t2e <<< 1) + w_te;
    assign w_h11 = w_t3e - w_t2e;

    // tangents, halved toward zero
    assign w_s0  = r_secl + 64'(w_dy);
    assign w_s1  = r_secr + 64'(w_dy);
    assign w_s0r = w_s0 + signed'({63'b0, w_s0[63]});
    assign w_s1r = w_s1 + signed'({63'b0, w_s1[63]});
    assign w_d0  = w_s0r >>> 1;
    assign w_d1  = w_s1r >>> 1;
    assign w_d0m = w_d0[63] ? 64'(-w_d0) : 64'(w_d0);
    assign w_d1m = w_d1[63] ? 64'(-w_d1) : 64'(w_d1);

    always_comb begin
        w_h    = w_h00;
        w_vm   = 64'(w_y0m);
        w_vneg = r_y0[31];
        case (r_step)
            STP_H01: begin
                w_h    = w_h01;
                w_vm   = 64'(w_y1m);
                w_vneg = r_y1[31];
            end
            STP_H10: begin
                w_h    = w_h10;
                w_vm   = w_d0m;
                w_vneg = w_d0[63];
            end
            STP_H11: begin
                w_h    = w_h11;
                w_vm   = w_d1m;
                w_vneg = w_d1[63];
            end
            default: begin
                w_h = w_h00;
            end
        endcase
    end
    assign w_hm = w_h[HW-1] ? HW'(-w_h) : HW'(w_h);

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_num    = '0;
        w_den    = w_dx33[31:0];
        w_is_div = 1'b0;
        case (r_step)
            STP_T: begin
                w_is_div = 1'b1;
                w_num    = {33'b0, w_qd33[31:0]} << F;
            end
            STP_T2: begin
                w_mul_a = MUL_AW'(r_t);
                w_mul_b = MUL_BW'(r_t);
            end
            STP_T3: begin
                w_mul_a = MUL_AW'(r_t2);
                w_mul_b = MUL_BW'(r_t);
            end
            STP_ML: begin
                w_mul_a = w_dx33[31:0];
                w_mul_b = MUL_BW'(w_dylm);
            end
            STP_DL: begin
                w_is_div = 1'b1;
                w_num    = w_prod[DIV_NW-1:0];
                w_den    = w_dxl33[31:0];
            end
            STP_MR: begin
                w_mul_a = w_dx33[31:0];
                w_mul_b = MUL_BW'(w_dyrm);
            end
            STP_DR: begin
                w_is_div = 1'b1;
                w_num    = w_prod[DIV_NW-1:0];
                w_den    = w_dxr33[31:0];
            end
            default: begin
                w_mul_a = MUL_AW'(w_hm);
                w_mul_b = w_vm;
            end
        endcase
    end

    assign w_skip = (((r_step == STP_ML) || (r_step == STP_DL)) && !r_left) ||
                    (((r_step == STP_MR) || (r_step == STP_DR)) && !r_right);
    assign w_mul_start = (r_state == S_ISSUE) && !w_skip && !w_is_div;
    assign w_div_start = (r_state == S_ISSUE) && !w_skip && w_is_div;
    assign w_unit_done = w_is_div ? w_div_done : w_mul_done;

    // scaled secant, saturated
    assign w_qm  = (w_quo[63:0] > SAT_LIM) ? SAT_LIM : w_quo[63:0];
    assign w_sec = ((r_step == STP_DL) ? w_dyl[32] : w_dyr[32]) ?
                   -signed'(w_qm) : signed'(w_qm);

    // basis term, saturated, then accumulate
    assign w_pm   = (w_prod > MUL_PW'(SAT_LIM)) ? SAT_LIM : w_prod[63:0];
    assign w_term = (w_h[HW-1] ^ w_vneg) ? -signed'(w_pm) : signed'(w_pm);
    assign w_sum  = r_acc + w_term;
    assign w_res  = r_acc >>> F;

    always_comb begin
        w_raddr = r_k[IW-1:0];
        if (r_state == S_NEXT_RD) begin
            w_raddr = w_k1[IW-1:0];
        end
    end

    assign w_we = (r_state == S_IDLE) && i_valid && (i_item.op == OP_APPEND) &&
                  (r_cnt < CW'(MAX_POINTS)) &&
                  ((r_cnt == '0) || (i_item.px > r_last_x));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last_x    = r_last_x;
        n_k         = r_k;
        n_q         = r_q;
        n_xm        = r_xm;
        n_ym        = r_ym;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_left      = r_left;
        n_right     = r_right;
        n_step      = r_step;
        n_t         = r_t;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_secl      = r_secl;
        n_secr      = r_secr;
        n_acc       = r_acc;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_ready;
        n_out_val   = r_out_val;
        n_out_st    = r_out_st;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_q       = i_item.qx;
                    n_res_val = '0;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                    case (i_item.op)
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        OP_APPEND: begin
                            if (r_cnt >= CW'(MAX_POINTS)) begin
                                n_res_st = ST_FULL;
                            end else if ((r_cnt != '0) && (i_item.px <= r_last_x)) begin
                                n_res_st = ST_ORDER;
                            end else begin
                                n_cnt    = r_cnt + CW'(1);
                                n_last_x = i_item.px;
                            end
                        end
                        OP_QUERY: begin
                            if (r_cnt == '0) begin
                                n_res_st = ST_RANGE;
                            end else begin
                                n_k     = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_res_st = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_rd_x == r_q) begin
                    n_res_val = r_rd_y;
                    n_state   = S_DONE;
                end else if (r_rd_x > r_q) begin
                    if (r_k == '0) begin
                        n_res_st = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_x1    = r_rd_x;
                        n_y1    = r_rd_y;
                        n_left  = r_k >= CW'(2);
                        n_right = w_k1 < r_cnt;
                        n_secl  = '0;
                        n_secr  = '0;
                        n_acc   = '0;
                        n_step  = STP_T;
                        n_state = (w_k1 < r_cnt) ? S_NEXT_RD : S_ISSUE;
                    end
                end else begin
                    n_xm = r_x0;
                    n_ym = r_y0;
                    n_x0 = r_rd_x;
                    n_y0 = r_rd_y;
                    n_k  = w_k1;
                    if (w_k1 == r_cnt) begin
                        n_res_st = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_NEXT_RD: begin
                n_state = S_NEXT_CHK;
            end
            S_NEXT_CHK: begin
                n_x2    = r_rd_x;
                n_y2    = r_rd_y;
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (w_skip) begin
                    n_step = t_step'(r_step + 4'd1);
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_unit_done) begin
                    n_step  = t_step'(r_step + 4'd1);
                    n_state = S_ISSUE;
                    case (r_step)
                        STP_T:  n_t  = w_quo[F-1:0];
                        STP_T2: n_t2 = w_prod[2*F-1:F];
                        STP_T3: n_t3 = w_prod[2*F-1:F];
                        STP_DL: n_secl = w_sec;
                        STP_DR: n_secr = w_sec;
                        STP_H00, STP_H01, STP_H10, STP_H11: begin
                            if (w_sum > w_lim_p) begin
                                n_acc = w_lim_p;
                            end else if (w_sum < w_lim_n) begin
                                n_acc = w_lim_n;
                            end else begin
                                n_acc = w_sum;
                            end
                            if (r_step == STP_H11) begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_acc = r_acc;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (w_res > I32_MAX) begin
                    n_res_val = 32'sh7FFF_FFFF;
                end else if (w_res < I32_MIN) begin
                    n_res_val = 32'sh8000_0000;
                end else begin
                    n_res_val = w_res[31:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res_val;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_x  <= n_last_x;
        r_k       <= n_k;
        r_q       <= n_q;
        r_xm      <= n_xm;
        r_ym      <= n_ym;
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_x2      <= n_x2;
        r_y2      <= n_y2;
        r_left    <= n_left;
        r_right   <= n_right;
        r_step    <= n_step;
        r_t       <= n_t;
        r_t2      <= n_t2;
        r_t3      <= n_t3;
        r_secl    <= n_secl;
        r_secr    <= n_secr;
        r_acc     <= n_acc;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out_val <= n_out_val;
        r_out_st  <= n_out_st;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_xmem[r_cnt[IW-1:0]] <= i_item.px;
            r_ymem[r_cnt[IW-1:0]] <= i_item.py;
        end
        r_rd_x <= r_xmem[w_raddr];
        r_rd_y <= r_ymem[w_raddr];
    end

    chti_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    chti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

endmodule

### rtl/cubic_hermite_table_interpolator_unit.sv
// Cubic Hermite table interpolator, signed Q(31-FRAC_BITS).FRAC_BITS. Beats on the
// input channel clear the table, append a knot (x strictly rising) or query a point;
// every beat gives exactly one result beat, in order. A two-beat queue sits between
// the input decode stage and the execution engine, so input beats are taken while a
// query runs or a result waits. Clear, append and the unused op go from idle straight to the
// result state in the engine. A query walks the knot store from the first entry, one knot per
// read (single registered read port), then reads the next knot if there is one, runs up to
// three restoring divisions (t and the two neighbouring secants) and up to eight
// multiplications on a shared 32x32 multiplier; a query that hits a stored x or falls
// outside the table ends at the scan.
`include "assert_macros.svh"

module cubic_hermite_table_interpolator_unit import chti_pkg::*; #(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chti_in_if.sink     i_in,
    chti_out_if.source  o_res
);

    logic    w_fr_valid;
    t_item   w_fr_item;
    logic    w_fr_ready;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_ready;
    t_qstat  w_qstat;
    t_status w_status;

    chti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_fr_valid),
        .o_item  (w_fr_item),
        .i_ready (w_fr_ready)
    );

    chti_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_item  (w_fr_item),
        .o_ready (w_fr_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_ready (w_q_ready),
        .o_stat  (w_qstat)
    );

    chti_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_ready  (w_q_ready),
        .o_valid  (o_res.valid),
        .o_value  (o_res.value),
        .o_status (w_status),
        .i_ready  (o_res.ready)
    );

    assign o_res.status = w_status;

    `CHTI_ASSERT(a_err_no_value, o_res.valid && (w_status != ST_OK) |-> (o_res.value == '0), "error beat carries a value")
    `CHTI_ASSERT(a_q_bound, w_qstat.cnt <= QCW'(QDEPTH), "queue count beyond depth")
    `CHTI_ASSERT(a_q_flags, w_qstat.full |-> !w_qstat.empty && !w_fr_ready, "queue flags disagree")
    `CHTI_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_res.valid, "result beat straight after reset")

endmodule

### tb/cubic_hermite_table_interpolator_unit_test.sv
`timescale 1ns / 1ps

module cubic_hermite_table_interpolator_unit_test;
    import chti_pkg::*;

    localparam int  KNOTS      = 64;
    localparam int  FB         = 16;
    localparam int  WATCHDOG   = 20000;
    localparam int  HOLD_LEN   = 3000;
    localparam int  DRAIN_WAIT = 600;
    localparam int  N_RANDOM   = 700;
    localparam longint LIM62   = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_op         op;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
        bit          typed;
        logic [31:0] val;
        t_status     st;
    } row_t;

    typedef struct {
        bit          typed;
        logic [31:0] val;
        t_status     st;
    } known_t;

    typedef struct {
        logic [31:0] val;
        t_status     st;
    } res_t;

    logic i_clk;
    logic i_rst_n;

    chti_in_if  in_if ();
    chti_out_if res_if ();

    cubic_hermite_table_interpolator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    int          knot_x [KNOTS];
    int          knot_y [KNOTS];
    int unsigned knot_n;

    known_t typed_q [$];
    res_t   expected_q [$];

    int  errors;
    int  beats_in, beats_out, n_query, n_ok, n_range, n_full, n_order;
    int  idle_pct_in, idle_pct_out;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch at beat %0d: %s got %h expected %h", beats_out, what, got, want);
    endtask

    function automatic longint clamp62(longint v);
        if (v > LIM62) return LIM62;
        if (v < -LIM62) return -LIM62;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
    endfunction

    function automatic longint mul62(longint a, longint b);
        longint unsigned ua, ub;
        longint p;
        ua = magn(a);
        ub = magn(b);
        if (ua != 0 && ub > longint'(unsigned'(LIM62)) / ua) p = LIM62;
        else p = longint'(ua * ub);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint slope_scaled(longint dyk, longint unsigned dx,
                                            longint unsigned dxk);
        longint unsigned ady, qq, rr, m;
        longint v;
        ady = magn(dyk);
        qq  = ady / dxk;
        rr  = ady % dxk;
        m   = dx * qq + (dx * rr) / dxk;
        v   = (m > longint'(unsigned'(LIM62))) ? LIM62 : longint'(m);
        return dyk < 0 ? -v : v;
    endfunction

    function automatic longint knot_tangent(int unsigned k, longint unsigned dx);
        longint sum;
        sum = 0;
        if (k > 0)
            sum += slope_scaled(longint'(knot_y[k]) - knot_y[k-1], dx,
                                longint'(knot_x[k]) - knot_x[k-1]);
        if (k + 1 < knot_n)
            sum += slope_scaled(longint'(knot_y[k+1]) - knot_y[k], dx,
                                longint'(knot_x[k+1]) - knot_x[k]);
        return clamp62(sum / 2);
    endfunction

    function automatic res_t interpolate(int q);
        res_t r;
        longint one, t, t2, t3, h00, h01, h10, h11, d0, d1, acc, v;
        longint unsigned dx, dq;
        int unsigned i;
        one = longint'(1) << FB;
        r.val = '0;
        r.st = ST_OK;
        if (knot_n == 0 || q < knot_x[0] || q > knot_x[knot_n-1]) begin
            r.st = ST_RANGE;
            return r;
        end
        for (int k = 0; k < knot_n; k++)
            if (knot_x[k] == q) begin
                r.val = knot_y[k];
                return r;
            end
        i = 0;
        for (int k = 0; k + 1 < knot_n; k++)
            if (knot_x[k] < q) i = k;
        dx  = longint'(knot_x[i+1]) - knot_x[i];
        dq  = longint'(q) - knot_x[i];
        t   = longint'((dq << FB) / dx);
        t2  = (t * t) / one;
        t3  = (t2 * t) / one;
        h00 = 2 * t3 - 3 * t2 + one;
        h01 = 3 * t2 - 2 * t3;
        h10 = t3 - 2 * t2 + t;
        h11 = t3 - t2;
        d0  = knot_tangent(i, dx);
        d1  = knot_tangent(i + 1, dx);
        acc = mul62(h00, knot_y[i]);
        acc = clamp62(acc + mul62(h01, knot_y[i+1]));
        acc = clamp62(acc + mul62(h10, d0));
        acc = clamp62(acc + mul62(h11, d1));
        if (acc >= 0) v = acc / one;
        else v = -((-acc + one - 1) / one);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.val = v[31:0];
        return r;
    endfunction

    function automatic res_t table_step(t_op op, int px, int py, int qx);
        res_t r;
        r.val = '0;
        r.st = ST_OK;
        case (op)
            OP_CLEAR: knot_n = 0;
            OP_APPEND: begin
                if (knot_n >= KNOTS) r.st = ST_FULL;
                else if (knot_n > 0 && px <= knot_x[knot_n-1]) r.st = ST_ORDER;
                else begin
                    knot_x[knot_n] = px;
                    knot_y[knot_n] = py;
                    knot_n++;
                end
            end
            OP_QUERY: r = interpolate(qx);
            default: ;
        endcase
        return r;
    endfunction

    // input monitor and watchdog
    always @(posedge i_clk) begin
        known_t kn;
        res_t   r;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                kn = typed_q.pop_front();
                r = table_step(t_op'(in_if.op), in_if.point_x, in_if.point_y,
                               in_if.query_x);
                if (kn.typed) begin
                    r.val = kn.val;
                    r.st = kn.st;
                end
                expected_q.push_back(r);
                beats_in++;
                if (in_if.op == OP_QUERY) n_query++;
            end
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG);
                $display("cubic_hermite_table_interpolator_unit_test: FAIL");
                $finish;
            end
        end
    end

    // result side: stalls, long hold, checking
    always @(posedge i_clk) begin
        res_t w;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("unexpected result beat: value %h status %0d",
                             res_if.value, res_if.status);
                end else begin
                    w = expected_q.pop_front();
                    if (res_if.value !== w.val) report_mismatch("value", res_if.value, w.val);
                    if (res_if.status !== w.st) report_mismatch("status", res_if.status, w.st);
                    case (w.st)
                        ST_OK:    n_ok++;
                        ST_RANGE: n_range++;
                        ST_FULL:  n_full++;
                        default:  n_order++;
                    endcase
                end
                beats_out++;
            end
            if (!hold_done && beats_out == 100) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= idle_pct_out);
            end
        end
    end

    task automatic send(t_op op, logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                        bit typed, logic [31:0] val, t_status st);
        known_t kn;
        kn.typed = typed;
        kn.val = val;
        kn.st = st;
        typed_q.push_back(kn);
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.point_x <= px;
        in_if.point_y <= py;
        in_if.query_x <= qx;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct_in) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct_in) @(posedge i_clk);
        end
    endtask

    task automatic send_rand(t_op op, logic [31:0] px, logic [31:0] py, logic [31:0] qx);
        send(op, px, py, qx, 1'b0, '0, ST_OK);
    endtask

    row_t dir_rows [] = '{
        '{OP_QUERY,  32'h0,        32'h0,        32'h0,        1, 32'h0,        ST_RANGE},
        '{OP_NONE,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h0,        ST_OK},
        '{OP_APPEND, 32'h0,        32'h00010000, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_APPEND, 32'h0,        32'h5,        32'h0,        1, 32'h0,        ST_ORDER},
        '{OP_APPEND, 32'hFFFFFFFB, 32'h5,        32'h0,        1, 32'h0,        ST_ORDER},
        '{OP_QUERY,  32'h0,        32'h0,        32'h0,        1, 32'h00010000, ST_OK},
        '{OP_APPEND, 32'h00020000, 32'h7FFFFFFF, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_APPEND, 32'h7FFFFFFF, 32'h80000000, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h00010000, 0, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h7FFFFFFF, 1, 32'h80000000, ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h80000000, 1, 32'h0,        ST_RANGE},
        '{OP_QUERY,  32'h0,        32'h0,        32'h7FFFFFFE, 0, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h00030000, 0, 32'h0,        ST_OK},
        '{OP_CLEAR,  32'h0,        32'h0,        32'h0,        1, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h0,        1, 32'h0,        ST_RANGE},
        '{OP_APPEND, 32'h80000000, 32'h7FFFFFFF, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_APPEND, 32'h80000001, 32'h80000000, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_APPEND, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,        1, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h80000001, 1, 32'h80000000, ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h0,        0, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h40000000, 0, 32'h0,        ST_OK},
        '{OP_QUERY,  32'h0,        32'h0,        32'h7FFFFFFF, 1, 32'h7FFFFFFF, ST_OK},
        '{OP_CLEAR,  32'h0,        32'h0,        32'h0,        1, 32'h0,        ST_OK}
    };

    task automatic random_sequence(bit force_full, inout int sent);
        longint xs [$];
        longint x, span, gap, qv;
        int n, m, sh;
        send_rand(OP_CLEAR, $urandom, $urandom, $urandom);
        sent++;
        n = force_full ? KNOTS : (($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 10));
        sh = $urandom_range(4, 26);
        x = longint'(int'($urandom)) >>> $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
            if (x > 64'sd2147483647) break;
            if (xs.size() > 0 && $urandom_range(15) == 0) begin
                send_rand(OP_APPEND, 32'(xs[$] - $urandom_range(0, 3)), $urandom, $urandom);
                sent++;
            end
            send_rand(OP_APPEND, x[31:0],
                      ($urandom_range(3) == 0) ? $urandom
                                               : int'($urandom) >>> $urandom_range(4, 14),
                      $urandom);
            sent++;
            xs.push_back(x);
            gap = 1 + ($urandom & ((longint'(1) << sh) - 1));
            x = x + gap;
        end
        if (force_full || xs.size() == KNOTS) begin
            send_rand(OP_APPEND, $urandom, $urandom, $urandom);
            sent++;
        end
        m = $urandom_range(1, 8);
        for (int k = 0; k < m; k++) begin
            span = xs[$] - xs[0];
            case ($urandom_range(9))
                0: qv = xs[$urandom_range(xs.size() - 1)];
                1: qv = ($urandom_range(1)) ? xs[0] - 1 - $urandom_range(255)
                                            : xs[$] + 1 + $urandom_range(255);
                default: qv = xs[0] + ((longint'($urandom) << 16 | $urandom_range(65535))
                                       % (span + 1));
            endcase
            send_rand(OP_QUERY, $urandom, $urandom, qv[31:0]);
            sent++;
        end
    endtask

    initial begin
        int sent;
        row_t rw;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        n_query = 0;
        n_ok = 0;
        n_range = 0;
        n_full = 0;
        n_order = 0;
        quiet_cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        idle_pct_in = 0;
        idle_pct_out = 0;
        knot_n = 0;
        i_rst_n = 1'b0;
        in_if.valid   <= 1'b0;
        in_if.op      <= OP_CLEAR;
        in_if.point_x <= '0;
        in_if.point_y <= '0;
        in_if.query_x <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            rw = dir_rows[r];
            send(rw.op, rw.px, rw.py, rw.qx, rw.typed, rw.val, rw.st);
        end

        sent = 0;
        random_sequence(1'b1, sent);
        while (sent < N_RANDOM) begin
            case (sent * 4 / N_RANDOM)
                0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
                1: begin idle_pct_in = 61; idle_pct_out = 0;  end
                2: begin idle_pct_in = 0;  idle_pct_out = 61; end
                default: begin idle_pct_in = 7; idle_pct_out = 7; end
            endcase
            if ($urandom_range(99) < 85) begin
                random_sequence(1'b0, sent);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_rand(t_op'($urandom_range(3)), $urandom, $urandom, $urandom);
                    sent++;
                end
            end
        end
        in_if.valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d beats in, %0d out, %0d queries; ok %0d range %0d full %0d order %0d",
                 beats_in, beats_out, n_query, n_ok, n_range, n_full, n_order);
        $display("idle phases on both sides and a %0d-cycle result hold; %0d mismatches",
                 HOLD_LEN, errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("cubic_hermite_table_interpolator_unit_test: PASS");
        end else begin
            $display("cubic_hermite_table_interpolator_unit_test: FAIL");
        end
        $finish;
    end

endmodule
